// File: rtl/i2cm_pkg.sv
// Package for the I2C master byte engine: command codes, phase numbers,
// register defaults and the structs passed between the engine's modules.
// No dependencies.
package i2cm_pkg;

  // Commands carried by an input item.
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_WAIT_ACK = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  // Phase numbers of a command sequence.
  localparam logic [3:0] PH_0 = 4'd0;
  localparam logic [3:0] PH_1 = 4'd1;
  localparam logic [3:0] PH_2 = 4'd2;
  localparam logic [3:0] PH_3 = 4'd3;
  localparam logic [3:0] PH_4 = 4'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_START_STOP  = 2'd1;
  localparam logic [1:0] REG_BIT_HALF    = 2'd2;
  localparam logic [1:0] REG_ACK_HIGH    = 2'd3;

  // Register reset values.
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0] START_STOP_RST  = 8'd4;
  localparam logic [7:0] BIT_HALF_RST    = 8'd2;
  localparam logic [7:0] ACK_HIGH_RST    = 8'd5;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [7:0] ack_timeout_ticks;
    logic [7:0] start_stop_ticks;
    logic [7:0] bit_half_ticks;
    logic [7:0] ack_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_enable;
    logic       sda_drive_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } res_t;

  // A phase length of zero counts as one tick.
  function automatic logic [7:0] eff_len(input logic [7:0] len);
    eff_len = (len == 8'd0) ? 8'd1 : len;
  endfunction

endpackage

// File: rtl/i2cm_cfg_regs.sv
// Configuration registers of the I2C master byte engine.
// Depends on i2cm_pkg.
module i2cm_cfg_regs
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  // Register writes take effect at the next edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_timeout_ticks <= ACK_TIMEOUT_RST;
      cfg_r.start_stop_ticks  <= START_STOP_RST;
      cfg_r.bit_half_ticks    <= BIT_HALF_RST;
      cfg_r.ack_high_ticks    <= ACK_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ACK_TIMEOUT: cfg_r.ack_timeout_ticks <= cfg_data;
        REG_START_STOP:  cfg_r.start_stop_ticks  <= cfg_data;
        REG_BIT_HALF:    cfg_r.bit_half_ticks    <= cfg_data;
        REG_ACK_HIGH:    cfg_r.ack_high_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/i2cm_core.sv
// Bus sequencer of the I2C master byte engine: holds the sequence state and
// computes one tick's result from the registered item. Depends on i2cm_pkg.
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  cmd_t       cmd_r, cmd_nxt;
  logic [3:0] ph_r, ph_nxt;
  logic [7:0] tc_r, tc_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic       ack_r, ack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       en_r, en_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       tof_r, tof_nxt;

  logic       cmd_ok, start_cmd;
  logic [7:0] tc_base, tc_inc;
  logic [3:0] bc_inc;
  logic       ss_done, half_done, ackh_done;
  logic       fin, err;

  // A command is taken only while idle and only if it is a known code.
  assign cmd_ok    = (item.command == CMD_START) || (item.command == CMD_STOP) ||
                     (item.command == CMD_WRITE) || (item.command == CMD_WAIT_ACK) ||
                     (item.command == CMD_READ);
  assign start_cmd = (cmd_r == CMD_NONE) && cmd_ok;

  // Tick counter step and the phase-length compares.
  assign tc_base   = start_cmd ? 8'd0 : tc_r;
  assign tc_inc    = tc_base + 8'd1;
  assign bc_inc    = (start_cmd ? 4'd0 : bc_r) + 4'd1;
  assign ss_done   = tc_inc >= eff_len(cfg.start_stop_ticks);
  assign half_done = tc_inc >= eff_len(cfg.bit_half_ticks);
  assign ackh_done = tc_inc >= eff_len(cfg.ack_high_ticks);

  // Next state and this tick's bus levels.
  always_comb begin
    cmd_nxt = cmd_r;
    ph_nxt  = ph_r;
    tc_nxt  = tc_r;
    bc_nxt  = bc_r;
    sh_nxt  = sh_r;
    ack_nxt = ack_r;
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    en_nxt  = en_r;
    rd_nxt  = rd_r;
    tof_nxt = tof_r;
    fin     = 1'b0;
    err     = 1'b0;

    if (start_cmd) begin
      cmd_nxt = cmd_t'(item.command);
      ph_nxt  = PH_0;
      tc_nxt  = 8'd0;
      bc_nxt  = 4'd0;
      if (item.command == CMD_WRITE) sh_nxt = item.write_data;
      if (item.command == CMD_READ) begin
        sh_nxt  = 8'd0;
        ack_nxt = item.send_ack;
      end
      if (item.command == CMD_STOP) tof_nxt = 1'b0;
    end

    unique case (cmd_nxt)
      CMD_START: begin
        en_nxt = 1'b1;
        if (ph_nxt == PH_0) begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
          tc_nxt  = ss_done ? 8'd0 : tc_inc;
          if (ss_done) ph_nxt = PH_1;
        end else if (ph_nxt == PH_1) begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
          tc_nxt  = ss_done ? 8'd0 : tc_inc;
          if (ss_done) ph_nxt = PH_2;
        end else begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
          fin     = 1'b1;
        end
      end
      CMD_STOP: begin
        en_nxt = 1'b1;
        if (ph_nxt == PH_0) begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
          ph_nxt  = PH_1;
          tc_nxt  = 8'd0;
        end else if (ph_nxt == PH_1) begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
          tc_nxt  = ss_done ? 8'd0 : tc_inc;
          if (ss_done) ph_nxt = PH_2;
        end else begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
          tc_nxt  = ss_done ? 8'd0 : tc_inc;
          if (ss_done) begin
            fin     = 1'b1;
            err     = tof_nxt;
            tof_nxt = 1'b0;
          end
        end
      end
      CMD_WRITE: begin
        en_nxt = 1'b1;
        if (ph_nxt == PH_0) begin
          scl_nxt = 1'b0;
          sda_nxt = sh_nxt[7];
          tc_nxt  = half_done ? 8'd0 : tc_inc;
          if (half_done) ph_nxt = PH_1;
        end else if (ph_nxt == PH_1) begin
          scl_nxt = 1'b1;
          tc_nxt  = half_done ? 8'd0 : tc_inc;
          if (half_done) ph_nxt = PH_2;
        end else begin
          scl_nxt = 1'b0;
          tc_nxt  = half_done ? 8'd0 : tc_inc;
          if (half_done) begin
            sh_nxt = {sh_nxt[6:0], 1'b0};
            bc_nxt = bc_inc;
            if (bc_inc >= BITS_PER_BYTE) fin = 1'b1;
            else ph_nxt = PH_0;
          end
        end
      end
      CMD_WAIT_ACK: begin
        if (ph_nxt == PH_0) begin
          en_nxt  = 1'b0;
          sda_nxt = 1'b1;
          scl_nxt = 1'b0;
          ph_nxt  = PH_1;
        end else if (ph_nxt == PH_1) begin
          en_nxt  = 1'b0;
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
          ph_nxt  = PH_2;
          tc_nxt  = 8'd0;
        end else if (ph_nxt == PH_2) begin
          en_nxt  = 1'b0;
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
          if (!item.sda_level) begin
            ph_nxt = PH_3;
            tc_nxt = 8'd0;
          end else if (tc_base >= cfg.ack_timeout_ticks) begin
            // Acknowledge timed out: fall into the stop sequence.
            cmd_nxt = CMD_STOP;
            ph_nxt  = PH_0;
            tc_nxt  = 8'd0;
            tof_nxt = 1'b1;
          end else begin
            tc_nxt = tc_inc;
          end
        end else begin
          scl_nxt = 1'b0;
          fin     = 1'b1;
        end
      end
      CMD_READ: begin
        if (ph_nxt == PH_0) begin
          en_nxt  = 1'b0;
          sda_nxt = 1'b1;
          scl_nxt = 1'b0;
          tc_nxt  = half_done ? 8'd0 : tc_inc;
          if (half_done) ph_nxt = PH_1;
        end else if (ph_nxt == PH_1) begin
          en_nxt  = 1'b0;
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
          // Sample SDA on the first tick of the SCL high half.
          if (tc_base == 8'd0) sh_nxt = {sh_nxt[6:0], item.sda_level};
          tc_nxt  = half_done ? 8'd0 : tc_inc;
          if (half_done) begin
            bc_nxt = bc_inc;
            ph_nxt = (bc_inc >= BITS_PER_BYTE) ? PH_2 : PH_0;
          end
        end else if (ph_nxt == PH_2) begin
          scl_nxt = 1'b0;
          en_nxt  = 1'b1;
          sda_nxt = !ack_nxt;
          tc_nxt  = half_done ? 8'd0 : tc_inc;
          if (half_done) ph_nxt = PH_3;
        end else if (ph_nxt == PH_3) begin
          scl_nxt = 1'b1;
          tc_nxt  = ackh_done ? 8'd0 : tc_inc;
          if (ackh_done) ph_nxt = PH_4;
        end else begin
          scl_nxt = 1'b0;
          rd_nxt  = sh_nxt;
          fin     = 1'b1;
        end
      end
      default: ;
    endcase

    if (fin) begin
      cmd_nxt = CMD_NONE;
      ph_nxt  = PH_0;
      tc_nxt  = 8'd0;
    end
  end

  // Result of this tick.
  always_comb begin
    res.scl_level        = scl_nxt;
    res.sda_drive_enable = en_nxt;
    res.sda_drive_level  = en_nxt ? sda_nxt : 1'b1;
    res.busy_res         = (cmd_nxt != CMD_NONE);
    res.done_res         = fin;
    res.read_data        = rd_nxt;
    res.ack_error        = err;
  end

  // State advances once for every item that moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_NONE;
      ph_r  <= PH_0;
      tc_r  <= 8'd0;
      bc_r  <= 4'd0;
      sh_r  <= 8'd0;
      ack_r <= 1'b0;
      scl_r <= 1'b1;
      sda_r <= 1'b1;
      en_r  <= 1'b1;
      rd_r  <= 8'd0;
      tof_r <= 1'b0;
    end else if (advance) begin
      cmd_r <= cmd_nxt;
      ph_r  <= ph_nxt;
      tc_r  <= tc_nxt;
      bc_r  <= bc_nxt;
      sh_r  <= sh_nxt;
      ack_r <= ack_nxt;
      scl_r <= scl_nxt;
      sda_r <= sda_nxt;
      en_r  <= en_nxt;
      rd_r  <= rd_nxt;
      tof_r <= tof_nxt;
    end
  end

endmodule

// File: rtl/i2c_master_byte_engine_top.sv
// Top level of the I2C master byte engine: input register, bus sequencer,
// result register and configuration registers.
// Depends on i2cm_pkg, i2cm_cfg_regs and i2cm_core.
//
//   Channel  Handshake               Carries
//   in_      in_valid / in_ready     command, write_data, send_ack, sda_level
//   out_     out_valid / out_ready   scl, sda drive, busy, done, read_data, error
//   cfg_     cfg_wr_en               cfg_index, cfg_data
//
// Each item is one bus tick and passes an input register and a result
// register. An accepted item waits in the input register, and its result is
// loaded into the result register once that register is free or drains. One item
// is taken per cycle; a stall on the result side stops the input only once
// both registers hold an item. Reset is synchronous and active low and puts
// the engine idle with SCL and SDA held high in the sequencer state.
module i2c_master_byte_engine_top
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  input  logic [7:0] in_write_data,
  input  logic       in_send_ack,
  input  logic       in_sda_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_drive_enable,
  output logic       out_sda_drive_level,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_data,
  output logic       out_ack_error,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r, s1_valid_nxt;
  res_t  core_res;
  res_t  out_res_r;
  logic  out_valid_r, out_valid_nxt;
  logic  advance;

  i2cm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The registered item moves on when the result register is free or drains.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Input register.
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.command    <= in_command;
      s1_item_r.write_data <= in_write_data;
      s1_item_r.send_ack   <= in_send_ack;
      s1_item_r.sda_level  <= in_sda_level;
    end
  end

  i2cm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (core_res)
  );

  // Result register.
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_scl_level        = out_res_r.scl_level;
  assign out_sda_drive_enable = out_res_r.sda_drive_enable;
  assign out_sda_drive_level  = out_res_r.sda_drive_level;
  assign out_busy_res         = out_res_r.busy_res;
  assign out_done_res         = out_res_r.done_res;
  assign out_read_data        = out_res_r.read_data;
  assign out_ack_error        = out_res_r.ack_error;

`ifndef NO_ASSERTIONS
  // Input stalls only when both registers are full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // An item that leaves the input register shows up as a result.
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item did not reach the result register");

  // An error comes only with done, and done ends the sequence.
  a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.ack_error) |-> (out_res_r.done_res && !out_res_r.busy_res))
    else $error("ack error without a finished sequence");
`endif

endmodule
